/* rtl/cssp_pkg.sv */
package cssp_pkg;

  localparam int CFG_W       = 7;
  localparam int STEPS_RESET = 16;
  localparam int NUM_TAPS    = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_CUBE,
    ST_KK,
    ST_K3,
    ST_KS2,
    ST_K2S,
    ST_WGT,
    ST_MAC,
    ST_LOADQ,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SS,
    MUL_S3,
    MUL_KK,
    MUL_K3,
    MUL_KS2,
    MUL_K2S
  } mul_op_t;

  typedef struct packed {
    logic       accept;
    mul_op_t    mul_op;
    logic       wgt_load;
    logic       mac_en;
    logic [1:0] mac_idx;
    logic       div_init;
    logic       div_step;
    logic       out_load;
    logic       k_inc;
    logic       shift_win;
  } cmd_t;

  typedef struct packed {
    logic seg;
    logic last_k;
    logic out_free;
  } stat_t;

endpackage

/* rtl/cssp_if.sv */
interface cssp_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic                          new_curve;
  logic signed [COORD_WIDTH-1:0] px;
  logic signed [COORD_WIDTH-1:0] py;
  logic signed [COORD_WIDTH-1:0] pz;

  modport source (output valid, output new_curve, output px, output py, output pz,
                  input ready);
  modport sink (input valid, input new_curve, input px, input py, input pz,
                output ready);
endinterface

interface cssp_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] cz;
  logic                          last_sample;

  modport source (output valid, output cx, output cy, output cz, output last_sample,
                  input ready);
  modport sink (input valid, input cx, input cy, input cz, input last_sample,
                output ready);
endinterface

interface cssp_cfg_if import cssp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/cubic_spline_segment_sampler_core.sv */
// channel | role | handshake    | word
// in_ch   | sink   | valid/ready | new_curve, px, py, pz
// out_ch  | source | valid/ready | cx, cy, cz, last_sample
// cfg_ch  | sink   | valid/ready | steps_per_segment (always ready)
//
// A point that does not close a segment is taken without leaving idle. A closing point
// yields S samples (S = effective steps), computed by one shared weight multiplier,
// a four-tap multiply-accumulate and a one-bit-per-cycle divider per axis.
// Reset (rst_n low, synchronous) clears the held-point count, steps to 16 and the output valid.
// An output stall holds the sampler at its next sample; in_ch reopens after the last one.
module cubic_spline_segment_sampler_core import cssp_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_STEPS   = 64
) (
  input logic          clk,
  input logic          rst_n,
  cssp_in_if.sink      in_ch,
  cssp_out_if.source   out_ch,
  cssp_cfg_if.sink     cfg_ch
);

  cmd_t  cmd;
  stat_t stat;

  cssp_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cssp_dp #(
    .COORD_WIDTH(COORD_WIDTH),
    .MAX_STEPS  (MAX_STEPS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_new_curve    (in_ch.new_curve),
    .in_px           (in_ch.px),
    .in_py           (in_ch.py),
    .in_pz           (in_ch.pz),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_data        (cfg_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cx          (out_ch.cx),
    .out_cy          (out_ch.cy),
    .out_cz          (out_ch.cz),
    .out_last_sample (out_ch.last_sample)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("sample loaded over a pending word");

  a_shift_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_win |-> (cmd.out_load && stat.last_k))
    else $error("window shifted before last sample");

  a_seg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && stat.seg) |=> !in_ch.ready)
    else $error("input reopened while segment in progress");
`endif

endmodule

/* rtl/cssp_ctrl.sv */
module cssp_ctrl import cssp_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam int CNTW = $clog2(COORD_WIDTH);

  state_t          state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && stat.seg) state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.mul_op = MUL_SS;
        state_nxt  = ST_CUBE;
      end
      ST_CUBE: begin
        cmd.mul_op = MUL_S3;
        state_nxt  = ST_KK;
      end
      ST_KK: begin
        cmd.mul_op = MUL_KK;
        state_nxt  = ST_K3;
      end
      ST_K3: begin
        cmd.mul_op = MUL_K3;
        state_nxt  = ST_KS2;
      end
      ST_KS2: begin
        cmd.mul_op = MUL_KS2;
        state_nxt  = ST_K2S;
      end
      ST_K2S: begin
        cmd.mul_op = MUL_K2S;
        state_nxt  = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_idx = cnt_r[1:0];
        if (cnt_r == CNTW'(NUM_TAPS - 1)) begin
          state_nxt = ST_LOADQ;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      ST_LOADQ: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CNTW'(COORD_WIDTH - 1);
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r - CNTW'(1);
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.last_k) begin
            cmd.shift_win = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cmd.k_inc = 1'b1;
            state_nxt = ST_KK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/cssp_dp.sv */
module cssp_dp import cssp_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int MAX_STEPS   = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  input  logic                          in_new_curve,
  input  logic signed [COORD_WIDTH-1:0] in_px,
  input  logic signed [COORD_WIDTH-1:0] in_py,
  input  logic signed [COORD_WIDTH-1:0] in_pz,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_cx,
  output logic signed [COORD_WIDTH-1:0] out_cy,
  output logic signed [COORD_WIDTH-1:0] out_cz,
  output logic                          out_last_sample
);

  localparam int CW = COORD_WIDTH;
  localparam int SW = $clog2(MAX_STEPS + 1);
  localparam int PW = 3 * SW;
  localparam int DW = PW + 3;
  localparam int NW = DW + CW;

  logic [CFG_W-1:0]  steps_r;
  logic [1:0]        held_r;
  logic [1:0]        held_eff;
  logic [CW-1:0]     pt      [3];
  logic [CW-1:0]     win_r   [3][3];
  logic [CW-1:0]     np_r    [3];
  logic [SW-1:0]     s_eff;
  logic [SW-1:0]     s_r, k_r;
  logic [2*SW-1:0]   s2_r, k2_r;
  logic [PW-1:0]     s3_r, k3_r, ks2_r, k2s_r;
  logic [SW-1:0]     mul_a;
  logic [2*SW-1:0]   mul_b;
  logic [PW-1:0]     mul_p;
  logic [DW-1:0]     w_r     [NUM_TAPS];
  logic [DW-1:0]     w_nxt   [NUM_TAPS];
  logic [DW-1:0]     d_r;
  logic [DW-1:0]     w_sel;
  logic [CW-1:0]     u_sel   [3];
  logic [NW-1:0]     acc_r   [3];
  logic [DW-1:0]     rem_r   [3];
  logic [CW-1:0]     quo_r   [3];
  logic [DW:0]       trial   [3];
  logic              ge      [3];
  logic [CW-1:0]     res     [3];
  logic              out_valid_r;
  logic [CW-1:0]     out_c_r [3];
  logic              out_last_r;

  assign pt[0]     = in_px;
  assign pt[1]     = in_py;
  assign pt[2]     = in_pz;
  assign held_eff  = in_new_curve ? 2'd0 : held_r;
  assign cfg_ready = 1'b1;

  assign stat.seg      = (held_eff == 2'd3);
  assign stat.last_k   = (k_r == s_r - SW'(1));
  assign stat.out_free = !out_valid_r || out_ready;

  always_comb begin
    if (steps_r == '0) begin
      s_eff = SW'(1);
    end else if (32'(steps_r) > 32'(MAX_STEPS)) begin
      s_eff = SW'(MAX_STEPS);
    end else begin
      s_eff = SW'(steps_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r     <= CFG_W'(STEPS_RESET);
      held_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) steps_r <= cfg_data;
      if (cmd.accept && held_eff != 2'd3) held_r <= held_eff + 2'd1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (held_eff != 2'd3) begin
        for (int c = 0; c < 3; c++) win_r[held_eff][c] <= pt[c];
      end else begin
        for (int c = 0; c < 3; c++) np_r[c] <= pt[c];
        s_r <= s_eff;
        k_r <= '0;
      end
    end else if (cmd.shift_win) begin
      for (int c = 0; c < 3; c++) begin
        win_r[0][c] <= win_r[1][c];
        win_r[1][c] <= win_r[2][c];
        win_r[2][c] <= np_r[c];
      end
    end
    if (cmd.k_inc) k_r <= k_r + SW'(1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_SS: begin
        mul_a = s_r;
        mul_b = (2*SW)'(s_r);
      end
      MUL_S3: begin
        mul_a = s_r;
        mul_b = s2_r;
      end
      MUL_KK: begin
        mul_a = k_r;
        mul_b = (2*SW)'(k_r);
      end
      MUL_K3: begin
        mul_a = k_r;
        mul_b = k2_r;
      end
      MUL_KS2: begin
        mul_a = k_r;
        mul_b = s2_r;
      end
      MUL_K2S: begin
        mul_a = s_r;
        mul_b = k2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      MUL_SS:  s2_r  <= mul_p[2*SW-1:0];
      MUL_S3:  s3_r  <= mul_p;
      MUL_KK:  k2_r  <= mul_p[2*SW-1:0];
      MUL_K3:  k3_r  <= mul_p;
      MUL_KS2: ks2_r <= mul_p;
      MUL_K2S: k2s_r <= mul_p;
      default: begin
      end
    endcase
  end

  always_comb begin
    w_nxt[0] = DW'(s3_r) + DW'(3) * DW'(k2s_r) - DW'(3) * DW'(ks2_r) - DW'(k3_r);
    w_nxt[1] = DW'(4) * DW'(s3_r) + DW'(3) * DW'(k3_r) - DW'(6) * DW'(k2s_r);
    w_nxt[2] = DW'(s3_r) + DW'(3) * DW'(ks2_r) + DW'(3) * DW'(k2s_r)
             - DW'(3) * DW'(k3_r);
    w_nxt[3] = DW'(k3_r);
  end

  assign w_sel = w_r[cmd.mac_idx];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.mac_idx == 2'd3) begin
        u_sel[c] = {~np_r[c][CW-1], np_r[c][CW-2:0]};
      end else begin
        u_sel[c] = {~win_r[cmd.mac_idx][c][CW-1], win_r[cmd.mac_idx][c][CW-2:0]};
      end
      trial[c] = {rem_r[c], quo_r[c][CW-1]};
      ge[c]    = (trial[c] >= {1'b0, d_r});
      res[c]   = {~quo_r[c][CW-1], quo_r[c][CW-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wgt_load) begin
      for (int i = 0; i < NUM_TAPS; i++) w_r[i] <= w_nxt[i];
      d_r <= DW'(6) * DW'(s3_r);
      for (int c = 0; c < 3; c++) acc_r[c] <= NW'(3) * NW'(s3_r);
    end else if (cmd.mac_en) begin
      for (int c = 0; c < 3; c++) acc_r[c] <= acc_r[c] + NW'(w_sel) * NW'(u_sel[c]);
    end
    if (cmd.div_init) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= acc_r[c][NW-1:CW];
        quo_r[c] <= acc_r[c][CW-1:0];
      end
    end else if (cmd.div_step) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= ge[c] ? DW'(trial[c] - {1'b0, d_r}) : trial[c][DW-1:0];
        quo_r[c] <= {quo_r[c][CW-2:0], ge[c]};
      end
    end
    if (cmd.out_load) begin
      for (int c = 0; c < 3; c++) out_c_r[c] <= res[c];
      out_last_r <= stat.last_k;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cx          = out_c_r[0];
  assign out_cy          = out_c_r[1];
  assign out_cz          = out_c_r[2];
  assign out_last_sample = out_last_r;

endmodule
